[hdl/kpi_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and control structures of the keyframe pose interpolator.
// No dependencies.

package kpi_pkg;

  localparam int NUM_CHANNELS_DEF = 21;
  localparam int MAX_KEYS_DEF     = 5;

  localparam int OP_W       = 2;
  localparam int CHAN_W     = 5;
  localparam int VALUE_W    = 32;
  localparam int STEPS_W    = 10;
  localparam int KEYS_OUT_W = 3;

  localparam logic [STEPS_W-1:0] STEPS_RESET = 10'd90;
  localparam logic [VALUE_W-1:0] DEPTH_RESET = 32'hFFF5_0000;
  localparam logic [VALUE_W-1:0] VALUE_MAX   = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_MIN   = 32'h8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_SAVE  = 2'd1,
    OP_PLAY  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PS_INPUT = 2'd0,
    PS_KEY   = 2'd1,
    PS_SUM   = 2'd2
  } pose_src_t;

  typedef struct packed {
    logic      pose_re;
    logic      pose_we;
    pose_src_t pose_src;
    logic      key_re;
    logic      key_we;
    logic      key_a_cap;
    logic      div_start;
    logic      inc_we;
    logic      emit_load;
    logic      emit_add;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
  } status_t;

endpackage

[hdl/kpi_in_if.sv]
`timescale 1ns / 1ps
// Input channel of the keyframe pose interpolator: opcode, channel and value.
// Depends on kpi_pkg.

interface kpi_in_if;
  logic                               valid;
  logic                               ready;
  logic [kpi_pkg::OP_W-1:0]           opcode;
  logic [kpi_pkg::CHAN_W-1:0]         channel;
  logic signed [kpi_pkg::VALUE_W-1:0] value;

  modport source(output valid, opcode, channel, value, input ready);
  modport sink(input valid, opcode, channel, value, output ready);
endinterface

[hdl/kpi_out_if.sv]
`timescale 1ns / 1ps
// Output channel of the keyframe pose interpolator: one pose channel per transaction.
// Depends on kpi_pkg.

interface kpi_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [kpi_pkg::CHAN_W-1:0]            out_channel;
  logic signed [kpi_pkg::VALUE_W-1:0]    out_value;
  logic                                  last;
  logic                                  playing;
  logic [kpi_pkg::KEYS_OUT_W-1:0]        keys_held;

  modport source(output valid, out_channel, out_value, last, playing, keys_held, input ready);
  modport sink(input valid, out_channel, out_value, last, playing, keys_held, output ready);
endinterface

[hdl/kpi_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module kpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/kpi_div.sv]
`timescale 1ns / 1ps
// Bit-serial signed divider: 33-bit difference over a 10-bit step count, one quotient
// bit per cycle, truncated toward zero and saturated to 32 bits. Depends on kpi_pkg.

module kpi_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [kpi_pkg::VALUE_W:0]         dividend,
  input  logic [kpi_pkg::STEPS_W-1:0]       divisor,
  output logic                              done,
  output logic [kpi_pkg::VALUE_W-1:0]       quotient
);

  localparam int VW = kpi_pkg::VALUE_W;
  localparam int SW = kpi_pkg::STEPS_W;

  logic               busy;
  logic [5:0]         cnt;
  logic               neg;
  logic [VW-1:0]      mag;
  logic [SW-1:0]      rem;
  logic [SW-1:0]      dvs;
  logic [VW:0]        dividend_abs;
  logic [SW:0]        trial;
  logic               ge;

  assign dividend_abs = dividend[VW] ? (~dividend + 1'b1) : dividend;
  assign trial        = {rem, mag[VW-1]};
  assign ge           = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(VW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[VW];
      mag <= dividend_abs[VW-1:0];
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? SW'(trial - {1'b0, dvs}) : trial[SW-1:0];
      mag <= {mag[VW-2:0], ge};
    end
  end

  always_comb begin
    if (!neg) begin
      quotient = (mag > kpi_pkg::VALUE_MAX) ? kpi_pkg::VALUE_MAX : mag;
    end else begin
      quotient = (mag > kpi_pkg::VALUE_MIN) ? kpi_pkg::VALUE_MIN : (~mag + 1'b1);
    end
  end

endmodule

[hdl/kpi_dp.sv]
`timescale 1ns / 1ps
// Datapath: pose, increment and keyframe memories, saturating adder, divider and
// output register. Depends on kpi_pkg, kpi_ram and kpi_div.

module kpi_dp #(
  parameter int NUM_CHANNELS = kpi_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_KEYS     = kpi_pkg::MAX_KEYS_DEF,
  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  kpi_pkg::cmd_t                         cmd,
  input  logic [CW-1:0]                         pose_raddr,
  input  logic [CW-1:0]                         pose_waddr,
  input  logic [KW+CW-1:0]                      key_raddr,
  input  logic [KW+CW-1:0]                      key_waddr,
  input  logic [CW-1:0]                         chan,
  input  logic [kpi_pkg::VALUE_W-1:0]           in_value,
  input  logic [kpi_pkg::STEPS_W-1:0]           eff_steps,
  input  logic                                  playing,
  input  logic [kpi_pkg::KEYS_OUT_W-1:0]        keys_held,
  output kpi_pkg::status_t                      st,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [kpi_pkg::CHAN_W-1:0]            out_channel,
  output logic [kpi_pkg::VALUE_W-1:0]           out_value,
  output logic                                  out_last,
  output logic                                  out_playing,
  output logic [kpi_pkg::KEYS_OUT_W-1:0]        out_keys_held
);

  localparam int VW        = kpi_pkg::VALUE_W;
  localparam int KEY_DEPTH = MAX_KEYS << CW;

  logic [NUM_CHANNELS-1:0] pose_vld;
  logic                    pose_rd_vld;
  logic                    pose_rd_ch0;
  logic [VW-1:0]           pose_rdata;
  logic [VW-1:0]           pose_q;
  logic [VW-1:0]           pose_wdata;
  logic [VW-1:0]           inc_rdata;
  logic [VW-1:0]           key_rdata;
  logic [VW-1:0]           key_a;
  logic [VW:0]             sum;
  logic [VW-1:0]           sum_sat;
  logic [VW:0]             diff;
  logic [VW-1:0]           div_q;
  logic                    div_done;

  assign pose_q = pose_rd_vld ? pose_rdata : (pose_rd_ch0 ? kpi_pkg::DEPTH_RESET : '0);

  assign sum     = {pose_q[VW-1], pose_q} + {inc_rdata[VW-1], inc_rdata};
  assign sum_sat = (sum[VW] != sum[VW-1]) ?
                   (sum[VW] ? kpi_pkg::VALUE_MIN : kpi_pkg::VALUE_MAX) : sum[VW-1:0];

  assign diff = {key_rdata[VW-1], key_rdata} - {key_a[VW-1], key_a};

  always_comb begin
    case (cmd.pose_src)
      kpi_pkg::PS_KEY: pose_wdata = key_rdata;
      kpi_pkg::PS_SUM: pose_wdata = sum_sat;
      default:         pose_wdata = in_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_vld <= '0;
    end else if (cmd.pose_we) begin
      pose_vld[pose_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pose_re) begin
      pose_rd_vld <= pose_vld[pose_raddr];
      pose_rd_ch0 <= (pose_raddr == '0);
    end
    if (cmd.key_a_cap) begin
      key_a <= key_rdata;
    end
  end

  kpi_ram #(.WIDTH(VW), .DEPTH(NUM_CHANNELS)) u_pose_ram (
    .clk  (clk),
    .we   (cmd.pose_we),
    .waddr(pose_waddr),
    .wdata(pose_wdata),
    .re   (cmd.pose_re),
    .raddr(pose_raddr),
    .rdata(pose_rdata)
  );

  kpi_ram #(.WIDTH(VW), .DEPTH(NUM_CHANNELS)) u_inc_ram (
    .clk  (clk),
    .we   (cmd.inc_we),
    .waddr(chan),
    .wdata(div_q),
    .re   (cmd.pose_re),
    .raddr(pose_raddr),
    .rdata(inc_rdata)
  );

  kpi_ram #(.WIDTH(VW), .DEPTH(KEY_DEPTH)) u_key_ram (
    .clk  (clk),
    .we   (cmd.key_we),
    .waddr(key_waddr),
    .wdata(pose_q),
    .re   (cmd.key_re),
    .raddr(key_raddr),
    .rdata(key_rdata)
  );

  kpi_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(diff),
    .divisor (eff_steps),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_channel   <= kpi_pkg::CHAN_W'(chan);
      out_value     <= cmd.emit_add ? sum_sat : pose_q;
      out_last      <= cmd.last;
      out_playing   <= playing;
      out_keys_held <= keys_held;
    end
  end

  assign st.out_free = !out_valid || out_ready;
  assign st.div_done = div_done;

endmodule

[hdl/kpi_ctrl.sv]
`timescale 1ns / 1ps
// Controller: opcode decode, playback state, configuration register and the
// sequencer that drives the datapath sweeps. Depends on kpi_pkg.

module kpi_ctrl #(
  parameter int NUM_CHANNELS = kpi_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_KEYS     = kpi_pkg::MAX_KEYS_DEF,
  localparam int CW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int KW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
  localparam int KCW = $clog2(MAX_KEYS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kpi_pkg::OP_W-1:0]        in_opcode,
  input  logic [kpi_pkg::CHAN_W-1:0]      in_channel,
  input  logic                            cfg_we,
  input  logic [kpi_pkg::STEPS_W-1:0]     cfg_wdata,
  input  kpi_pkg::status_t                st,
  output kpi_pkg::cmd_t                   cmd,
  output logic [CW-1:0]                   pose_raddr,
  output logic [CW-1:0]                   pose_waddr,
  output logic [KW+CW-1:0]                key_raddr,
  output logic [KW+CW-1:0]                key_waddr,
  output logic [CW-1:0]                   chan,
  output logic [kpi_pkg::STEPS_W-1:0]     eff_steps,
  output logic                            playing,
  output logic [kpi_pkg::KEYS_OUT_W-1:0]  keys_held
);

  localparam int SW = kpi_pkg::STEPS_W;
  localparam logic [CW-1:0] LAST_CH = CW'(NUM_CHANNELS - 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SAVE_RD  = 9'b000000010,
    S_SAVE_WR  = 9'b000000100,
    S_INC_RDA  = 9'b000001000,
    S_INC_RDB  = 9'b000010000,
    S_INC_DIV  = 9'b000100000,
    S_INC_WAIT = 9'b001000000,
    S_EMIT_RD  = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  chan_next;
  logic [KCW-1:0] key_count, key_count_next;
  logic           running, running_next;
  logic [KW-1:0]  segment, segment_next;
  logic [SW-1:0]  step_count, step_count_next;
  logic [SW-1:0]  steps_reg;
  logic           loading, loading_next;
  logic           emit_add, emit_add_next;
  logic           seg_end;

  assign eff_steps = (steps_reg == '0) ? SW'(1) : steps_reg;
  assign playing   = running;
  assign keys_held = kpi_pkg::KEYS_OUT_W'(key_count);
  assign in_ready  = (state == S_IDLE);
  assign seg_end   = ({1'b0, KCW'(segment)} + (KCW + 1)'(3)) > {1'b0, key_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chan       <= '0;
      key_count  <= '0;
      running    <= 1'b0;
      segment    <= '0;
      step_count <= '0;
      steps_reg  <= kpi_pkg::STEPS_RESET;
      loading    <= 1'b0;
      emit_add   <= 1'b0;
    end else begin
      state      <= state_next;
      chan       <= chan_next;
      key_count  <= key_count_next;
      running    <= running_next;
      segment    <= segment_next;
      step_count <= step_count_next;
      loading    <= loading_next;
      emit_add   <= emit_add_next;
      if (cfg_we) begin
        steps_reg <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_next      = state;
    chan_next       = chan;
    key_count_next  = key_count;
    running_next    = running;
    segment_next    = segment;
    step_count_next = step_count;
    loading_next    = loading;
    emit_add_next   = emit_add;
    cmd             = '0;
    cmd.pose_src    = kpi_pkg::PS_INPUT;
    pose_raddr      = chan;
    pose_waddr      = chan;
    key_raddr       = {segment, chan};
    key_waddr       = {KW'(key_count), chan};

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (kpi_pkg::op_t'(in_opcode))
            kpi_pkg::OP_WRITE: begin
              if (32'(in_channel) < NUM_CHANNELS) begin
                cmd.pose_we  = 1'b1;
                cmd.pose_src = kpi_pkg::PS_INPUT;
                pose_waddr   = CW'(in_channel);
              end
            end
            kpi_pkg::OP_SAVE: begin
              if (key_count < KCW'(MAX_KEYS)) begin
                chan_next  = '0;
                state_next = S_SAVE_RD;
              end
            end
            kpi_pkg::OP_PLAY: begin
              if (!running && key_count > KCW'(1)) begin
                segment_next    = '0;
                step_count_next = '0;
                loading_next    = 1'b1;
                chan_next       = '0;
                state_next      = S_INC_RDA;
              end else begin
                running_next = 1'b0;
              end
            end
            kpi_pkg::OP_TICK: begin
              chan_next = '0;
              if (running && step_count >= eff_steps) begin
                emit_add_next = 1'b0;
                if (seg_end) begin
                  segment_next = '0;
                  running_next = 1'b0;
                  state_next   = S_EMIT_RD;
                end else begin
                  segment_next    = segment + KW'(1);
                  step_count_next = '0;
                  loading_next    = 1'b0;
                  state_next      = S_INC_RDA;
                end
              end else begin
                emit_add_next = running;
                if (running) begin
                  step_count_next = step_count + SW'(1);
                end
                state_next = S_EMIT_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SAVE_RD: begin
        cmd.pose_re = 1'b1;
        state_next  = S_SAVE_WR;
      end
      S_SAVE_WR: begin
        cmd.key_we = 1'b1;
        if (chan == LAST_CH) begin
          key_count_next = key_count + KCW'(1);
          state_next     = S_IDLE;
        end else begin
          chan_next  = chan + CW'(1);
          state_next = S_SAVE_RD;
        end
      end
      S_INC_RDA: begin
        cmd.key_re = 1'b1;
        state_next = S_INC_RDB;
      end
      S_INC_RDB: begin
        cmd.key_re    = 1'b1;
        key_raddr     = {segment + KW'(1), chan};
        cmd.key_a_cap = 1'b1;
        if (loading) begin
          cmd.pose_we  = 1'b1;
          cmd.pose_src = kpi_pkg::PS_KEY;
        end
        state_next = S_INC_DIV;
      end
      S_INC_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_INC_WAIT;
      end
      S_INC_WAIT: begin
        if (st.div_done) begin
          cmd.inc_we = 1'b1;
          if (chan == LAST_CH) begin
            chan_next = '0;
            if (loading) begin
              running_next = 1'b1;
              loading_next = 1'b0;
              state_next   = S_IDLE;
            end else begin
              state_next = S_EMIT_RD;
            end
          end else begin
            chan_next  = chan + CW'(1);
            state_next = S_INC_RDA;
          end
        end
      end
      S_EMIT_RD: begin
        cmd.pose_re = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.emit_add  = emit_add;
          cmd.last      = (chan == LAST_CH);
          if (emit_add) begin
            cmd.pose_we  = 1'b1;
            cmd.pose_src = kpi_pkg::PS_SUM;
          end
          if (chan == LAST_CH) begin
            state_next = S_IDLE;
          end else begin
            cmd.pose_re = 1'b1;
            pose_raddr  = chan + CW'(1);
            chan_next   = chan + CW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_running_needs_keys: assert property (@(posedge clk) disable iff (rst)
    running |-> key_count >= KCW'(2))
    else $error("playback running with fewer than two keyframes");

  a_segment_in_range: assert property (@(posedge clk) disable iff (rst)
    running |-> ({1'b0, KCW'(segment)} + (KCW + 1)'(2)) <= {1'b0, key_count})
    else $error("current segment has no following keyframe");

  a_key_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= KCW'(MAX_KEYS))
    else $error("keyframe count beyond capacity");

  a_start_after_sweep: assert property (@(posedge clk) disable iff (rst)
    $rose(running) |-> $past(state == S_INC_WAIT))
    else $error("playback started without an increment sweep");
`endif

endmodule

[hdl/keyframe_pose_interpolator.sv]
`timescale 1ns / 1ps
// Top level of the keyframe pose interpolator: controller plus datapath.
// Depends on kpi_pkg, kpi_in_if, kpi_out_if, kpi_ctrl and kpi_dp.

// The block takes one transaction at a time. A channel write is done as it is accepted.
// A tick returns NUM_CHANNELS result transactions, one per cycle once the first pose word
// is read and while the output is not stalled. A save copies the pose into keyframe
// memory. Starting playback and a tick that crosses into a new segment recompute every
// increment through the bit-serial divider, one quotient bit per cycle; such a tick then
// emits the pose as usual. Configuration is to be written only between transactions; the
// block itself does not enforce this.

module keyframe_pose_interpolator #(
  parameter int NUM_CHANNELS = kpi_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_KEYS     = kpi_pkg::MAX_KEYS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [kpi_pkg::STEPS_W-1:0]  cfg_wdata,
  kpi_in_if.sink                       in_ch,
  kpi_out_if.source                    out_ch
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  kpi_pkg::cmd_t                   cmd;
  kpi_pkg::status_t                st;
  logic [CW-1:0]                   pose_raddr;
  logic [CW-1:0]                   pose_waddr;
  logic [KW+CW-1:0]                key_raddr;
  logic [KW+CW-1:0]                key_waddr;
  logic [CW-1:0]                   chan;
  logic [kpi_pkg::STEPS_W-1:0]     eff_steps;
  logic                            playing;
  logic [kpi_pkg::KEYS_OUT_W-1:0]  keys_held;

  kpi_ctrl #(.NUM_CHANNELS(NUM_CHANNELS), .MAX_KEYS(MAX_KEYS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_opcode (in_ch.opcode),
    .in_channel(in_ch.channel),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .st        (st),
    .cmd       (cmd),
    .pose_raddr(pose_raddr),
    .pose_waddr(pose_waddr),
    .key_raddr (key_raddr),
    .key_waddr (key_waddr),
    .chan      (chan),
    .eff_steps (eff_steps),
    .playing   (playing),
    .keys_held (keys_held)
  );

  kpi_dp #(.NUM_CHANNELS(NUM_CHANNELS), .MAX_KEYS(MAX_KEYS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .pose_raddr   (pose_raddr),
    .pose_waddr   (pose_waddr),
    .key_raddr    (key_raddr),
    .key_waddr    (key_waddr),
    .chan         (chan),
    .in_value     (in_ch.value),
    .eff_steps    (eff_steps),
    .playing      (playing),
    .keys_held    (keys_held),
    .st           (st),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_channel  (out_ch.out_channel),
    .out_value    (out_ch.out_value),
    .out_last     (out_ch.last),
    .out_playing  (out_ch.playing),
    .out_keys_held(out_ch.keys_held)
  );

endmodule
